// File: rtl/csd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the cascade split distance block.
// Depends on nothing; every other file imports it.
package csd_pkg;

	localparam int NUM_W     = 50;
	localparam int DEN_W     = 32;
	localparam int CNT_W     = 5;
	localparam int LOG_W     = 29;
	localparam int FRAC_BITS = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_PLANES = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	localparam logic [1:0] REG_NEAR   = 2'd0;
	localparam logic [1:0] REG_FAR    = 2'd1;
	localparam logic [1:0] REG_WEIGHT = 2'd2;
	localparam logic [1:0] REG_COUNT  = 2'd3;

	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam logic [31:0] SAT_NEG    = 32'h8000_0000;
	localparam logic [NUM_W-1:0] TWO_POW_33 = NUM_W'(1) << 33;

	typedef struct packed {
		logic [31:0]      near_d;
		logic [31:0]      far_d;
		logic [16:0]      weight;
		logic [CNT_W-1:0] count;
		logic             planes_bad;
	} cfg_t;

	typedef struct packed {
		logic [31:0] near_b;
		logic [31:0] far_b;
		logic [31:0] scale;
		logic [31:0] offset;
	} entry_t;

	typedef struct packed {
		logic [2:0] idx;
		logic [1:0] status;
	} qitem_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [31:0] neg_sat(input logic [NUM_W-1:0] q);
		logic [31:0] r;
		if (q >= NUM_W'(SAT_NEG)) r = SAT_NEG;
		else r = 32'd0 - q[31:0];
		return r;
	endfunction

endpackage

// File: rtl/cascade_split_distances.sv
`timescale 1ns / 1ps
// Cascade split distances: near/far boundaries and projection depth terms per subfrustum.
// Depends on csd_pkg, csd_engine, csd_front, csd_fifo and csd_back.
//
// After reset and after every configuration write, a sequencer computes all split
// boundaries and depth terms into a table (nothing when the planes are invalid), one
// boundary at a time with separate multiply steps and one iterative 50-step divider;
// in_stall stays high during this pass (the 24 iterative square roots of the exp2
// chain dominate each inner boundary). Afterwards one index is accepted every cycle
// while the queue is not full; its result passes through the queue into the output
// register, where it is held until taken. A two-entry queue separates the accepting
// side from the output side.
module cascade_split_distances import csd_pkg::*; #(
	parameter int MAX_SPLITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         sub_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        split_near,
	output logic [31:0]        split_far,
	output logic signed [31:0] depth_scale,
	output logic signed [31:0] depth_offset,
	output logic [1:0]         status
);

	localparam int IDX_W = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;

	logic [31:0]      near_q;
	logic [31:0]      far_q;
	logic [16:0]      weight_q;
	logic [3:0]       count_q;
	cfg_t             cfg;
	logic             busy;
	logic             full;
	logic             push;
	qitem_t           push_item;
	logic             pop;
	logic             not_empty;
	qitem_t           head;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= 32'd65536;
			far_q    <= 32'd6553600;
			weight_q <= 17'd32768;
			count_q  <= 4'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEAR:   near_q   <= cfg_data;
				REG_FAR:    far_q    <= cfg_data;
				REG_WEIGHT: weight_q <= cfg_data[16:0];
				REG_COUNT:  count_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.near_d = near_q;
		cfg.far_d  = far_q;
		cfg.weight = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
		if (count_q == 4'd0) cfg.count = CNT_W'(1);
		else if ({1'b0, count_q} > CNT_W'(MAX_SPLITS)) cfg.count = CNT_W'(MAX_SPLITS);
		else cfg.count = {1'b0, count_q};
		cfg.planes_bad = (near_q == 32'd0) || (far_q <= near_q);
	end

	csd_engine #(.MAX_SPLITS(MAX_SPLITS)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.cfg      (cfg),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.busy     (busy)
	);

	csd_front u_front (
		.in_valid    (in_valid),
		.sub_index   (sub_index),
		.cfg         (cfg),
		.engine_busy (busy),
		.queue_full  (full),
		.in_stall    (in_stall),
		.push        (push),
		.push_item   (push_item)
	);

	csd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	csd_back #(.MAX_SPLITS(MAX_SPLITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_valid  (not_empty),
		.head         (head),
		.rd_entry     (rd_entry),
		.out_stall    (out_stall),
		.pop          (pop),
		.rd_addr      (rd_addr),
		.out_valid    (out_valid),
		.split_near   (split_near),
		.split_far    (split_far),
		.depth_scale  (depth_scale),
		.depth_offset (depth_offset),
		.status       (status)
	);

endmodule

// File: rtl/csd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on csd_pkg.
module csd_div import csd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             run_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             qbit;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign qbit    = rem_sh >= {1'b0, den_q};
	assign rem_sub = qbit ? rem_sh - {1'b0, den_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (run_q) begin
			rem_q <= rem_sub[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// File: rtl/csd_engine.sv
`timescale 1ns / 1ps
// Sequencer: computes every split boundary and depth term into a table unless the planes are invalid.
// Depends on csd_pkg and csd_div.
module csd_engine import csd_pkg::*; #(
	parameter int MAX_SPLITS = 8,
	localparam int IDX_W = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  cfg_t             cfg,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_entry,
	output logic             busy
);

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_NORM, S_LMUL, S_LACC, S_KSTART, S_UDIV, S_EDIV,
		S_SQRT, S_RMUL, S_RACC, S_NMUL, S_LOG, S_B1, S_B2, S_B3, S_DTERM,
		S_Q1, S_Q2
	} state_t;

	state_t           state_q;
	logic             lsel_q;
	logic [31:0]      norm_v_q;
	logic [4:0]       norm_p_q;
	logic [30:0]      lm_q;
	logic [61:0]      lprod_q;
	logic [23:0]      lfrac_q;
	logic [4:0]       lstep_q;
	logic [LOG_W-1:0] ln_q;
	logic [LOG_W-1:0] lf_q;
	logic [CNT_W-1:0] k_q;
	logic [32:0]      uni_q;
	logic [32:0]      e_q;
	logic [30:0]      r_q;
	logic [31:0]      s_q;
	logic [4:0]       j_q;
	logic [63:0]      sq_v_q;
	logic [63:0]      sq_res_q;
	logic [4:0]       sq_i_q;
	logic [62:0]      mprod_q;
	logic [31:0]      lg_q;
	logic [48:0]      p1_q;
	logic [49:0]      p2_q;
	logic [31:0]      prev_q;
	logic [31:0]      cur_q;
	logic [31:0]      d_q;
	logic [31:0]      scale_q;
	div_req_t         div_req_q;
	div_rsp_t         div_rsp;
	entry_t           table_q [MAX_SPLITS];

	logic [31:0]      lt;
	logic [23:0]      lfrac_n;
	logic [LOG_W-1:0] ldiff;
	logic [5:0]       sq_sh;
	logic [63:0]      sq_bit;
	logic [63:0]      sq_trial;
	logic [63:0]      sq_res_n;
	logic [63:0]      sq_v_n;
	logic             ef_bit;
	logic [8:0]       ei;
	logic [63:0]      lg_raw;
	logic [31:0]      lg_clamp;
	logic [16:0]      w_c;
	logic [50:0]      blend_sum;
	logic [31:0]      d_n;
	logic [IDX_W-1:0] wr_addr;

	csd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_comb begin
		lt      = lprod_q[61:30];
		lfrac_n = {lfrac_q[22:0], lt[31]};
		ldiff   = (lf_q > ln_q) ? lf_q - ln_q : '0;
		sq_sh   = 6'd62 - {sq_i_q, 1'b0};
		sq_bit  = 64'd1 << sq_sh;
		sq_trial = sq_res_q + sq_bit;
		if (sq_v_q >= sq_trial) begin
			sq_v_n   = sq_v_q - sq_trial;
			sq_res_n = (sq_res_q >> 1) + sq_bit;
		end else begin
			sq_v_n   = sq_v_q;
			sq_res_n = sq_res_q >> 1;
		end
		ef_bit = e_q[6'(FRAC_BITS) - {1'b0, j_q}];
		ei     = e_q[32:24];
		if (ei > 9'd31) lg_raw = {32'd0, cfg.far_d};
		else if (ei <= 9'd30) lg_raw = {1'b0, mprod_q} >> (5'd30 - ei[4:0]);
		else lg_raw = {mprod_q, 1'b0};
		lg_clamp  = (lg_raw > {32'd0, cfg.far_d}) ? cfg.far_d : lg_raw[31:0];
		w_c       = WEIGHT_ONE - cfg.weight;
		blend_sum = {2'b0, p1_q} + {1'b0, p2_q};
		d_n       = (cur_q > prev_q) ? cur_q - prev_q : 32'd0;
		wr_addr   = IDX_W'(k_q - CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_START;
			div_req_q.start <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (restart) begin
				state_q <= S_START;
			end else begin
				case (state_q)
					S_IDLE: ;
					S_START: begin
						if (cfg.planes_bad) begin
							state_q <= S_IDLE;
						end else begin
							norm_v_q <= cfg.near_d;
							norm_p_q <= 5'd31;
							lsel_q   <= 1'b0;
							state_q  <= S_NORM;
						end
					end
					S_NORM: begin
						if (norm_v_q[31]) begin
							lm_q    <= norm_v_q[31:1];
							lfrac_q <= '0;
							lstep_q <= '0;
							state_q <= S_LMUL;
						end else begin
							norm_v_q <= norm_v_q << 1;
							norm_p_q <= norm_p_q - 5'd1;
						end
					end
					S_LMUL: begin
						lprod_q <= 62'(lm_q) * 62'(lm_q);
						state_q <= S_LACC;
					end
					S_LACC: begin
						lm_q    <= lt[31] ? lt[31:1] : lt[30:0];
						lfrac_q <= lfrac_n;
						lstep_q <= lstep_q + 5'd1;
						state_q <= S_LMUL;
						if (lstep_q == 5'(FRAC_BITS - 1)) begin
							if (!lsel_q) begin
								ln_q     <= {norm_p_q, lfrac_n};
								norm_v_q <= cfg.far_d;
								norm_p_q <= 5'd31;
								lsel_q   <= 1'b1;
								state_q  <= S_NORM;
							end else begin
								lf_q    <= {norm_p_q, lfrac_n};
								k_q     <= CNT_W'(1);
								prev_q  <= cfg.near_d;
								state_q <= S_KSTART;
							end
						end
					end
					S_KSTART: begin
						if (k_q == cfg.count) begin
							cur_q   <= cfg.far_d;
							state_q <= S_DTERM;
						end else begin
							div_req_q.start <= 1'b1;
							div_req_q.num   <= NUM_W'(37'(cfg.far_d - cfg.near_d) * 37'(k_q));
							div_req_q.den   <= DEN_W'(cfg.count);
							state_q <= S_UDIV;
						end
					end
					S_UDIV: begin
						if (div_rsp.done) begin
							uni_q <= {1'b0, cfg.near_d} + div_rsp.quo[32:0];
							div_req_q.start <= 1'b1;
							div_req_q.num   <= NUM_W'(34'(ldiff) * 34'(k_q));
							div_req_q.den   <= DEN_W'(cfg.count);
							state_q <= S_EDIV;
						end
					end
					S_EDIV: begin
						if (div_rsp.done) begin
							e_q      <= div_rsp.quo[32:0];
							r_q      <= 31'h4000_0000;
							s_q      <= 32'h8000_0000;
							j_q      <= 5'd1;
							sq_v_q   <= 64'd1 << 61;
							sq_res_q <= '0;
							sq_i_q   <= '0;
							state_q  <= S_SQRT;
						end
					end
					S_SQRT: begin
						sq_v_q   <= sq_v_n;
						sq_res_q <= sq_res_n;
						sq_i_q   <= sq_i_q + 5'd1;
						if (sq_i_q == 5'd31) begin
							s_q <= sq_res_n[31:0];
							if (ef_bit) begin
								state_q <= S_RMUL;
							end else if (j_q == 5'(FRAC_BITS)) begin
								state_q <= S_NMUL;
							end else begin
								j_q      <= j_q + 5'd1;
								sq_v_q   <= {2'b0, sq_res_n[31:0], 30'd0};
								sq_res_q <= '0;
								sq_i_q   <= '0;
							end
						end
					end
					S_RMUL: begin
						mprod_q <= 63'(r_q) * 63'(s_q);
						state_q <= S_RACC;
					end
					S_RACC: begin
						r_q <= mprod_q[60:30];
						if (j_q == 5'(FRAC_BITS)) begin
							state_q <= S_NMUL;
						end else begin
							j_q      <= j_q + 5'd1;
							sq_v_q   <= {2'b0, s_q, 30'd0};
							sq_res_q <= '0;
							sq_i_q   <= '0;
							state_q  <= S_SQRT;
						end
					end
					S_NMUL: begin
						mprod_q <= 63'(cfg.near_d) * 63'(r_q);
						state_q <= S_LOG;
					end
					S_LOG: begin
						lg_q    <= lg_clamp;
						state_q <= S_B1;
					end
					S_B1: begin
						p1_q    <= 49'(lg_q) * 49'(cfg.weight);
						state_q <= S_B2;
					end
					S_B2: begin
						p2_q    <= 50'(uni_q) * 50'(w_c);
						state_q <= S_B3;
					end
					S_B3: begin
						cur_q   <= blend_sum[47:16];
						state_q <= S_DTERM;
					end
					S_DTERM: begin
						d_q <= d_n;
						if (d_n == 32'd0) begin
							table_q[wr_addr] <= '{near_b: prev_q, far_b: cur_q,
								scale: SAT_NEG, offset: SAT_NEG};
							prev_q <= cur_q;
							k_q    <= k_q + CNT_W'(1);
							state_q <= (k_q == cfg.count) ? S_IDLE : S_KSTART;
						end else begin
							div_req_q.start <= 1'b1;
							div_req_q.num   <= TWO_POW_33;
							div_req_q.den   <= d_n;
							state_q <= S_Q1;
						end
					end
					S_Q1: begin
						if (div_rsp.done) begin
							scale_q <= neg_sat(div_rsp.quo);
							div_req_q.start <= 1'b1;
							div_req_q.num   <= NUM_W'({33'(cur_q) + 33'(prev_q), 16'd0});
							div_req_q.den   <= d_q;
							state_q <= S_Q2;
						end
					end
					S_Q2: begin
						if (div_rsp.done) begin
							table_q[wr_addr] <= '{near_b: prev_q, far_b: cur_q,
								scale: scale_q, offset: neg_sat(div_rsp.quo)};
							prev_q <= cur_q;
							k_q    <= k_q + CNT_W'(1);
							state_q <= (k_q == cfg.count) ? S_IDLE : S_KSTART;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign rd_entry = table_q[rd_addr];
	assign busy     = (state_q != S_IDLE);

endmodule

// File: rtl/csd_front.sv
`timescale 1ns / 1ps
// Front end: accepts an index, classifies it and pushes it to the queue.
// Depends on csd_pkg.
module csd_front import csd_pkg::*; (
	input  logic       in_valid,
	input  logic [2:0] sub_index,
	input  cfg_t       cfg,
	input  logic       engine_busy,
	input  logic       queue_full,
	output logic       in_stall,
	output logic       push,
	output qitem_t     push_item
);

	assign in_stall = engine_busy | queue_full;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		push_item.idx = sub_index;
		if ({2'b0, sub_index} >= cfg.count) push_item.status = ST_RANGE;
		else if (cfg.planes_bad) push_item.status = ST_PLANES;
		else push_item.status = ST_OK;
	end

endmodule

// File: rtl/csd_fifo.sv
`timescale 1ns / 1ps
// Short queue between front and back end.
// Depends on csd_pkg.
module csd_fifo import csd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output qitem_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	qitem_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full      = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

// File: rtl/csd_back.sv
`timescale 1ns / 1ps
// Back end: looks up the table entry of the queued item and drives the result.
// Depends on csd_pkg.
module csd_back import csd_pkg::*; #(
	parameter int MAX_SPLITS = 8,
	localparam int IDX_W = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               queue_valid,
	input  qitem_t             head,
	input  entry_t             rd_entry,
	input  logic               out_stall,
	output logic               pop,
	output logic [IDX_W-1:0]   rd_addr,
	output logic               out_valid,
	output logic [31:0]        split_near,
	output logic [31:0]        split_far,
	output logic signed [31:0] depth_scale,
	output logic signed [31:0] depth_offset,
	output logic [1:0]         status
);

	logic out_valid_q;

	assign rd_addr   = IDX_W'(head.idx);
	assign pop       = queue_valid & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (pop) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status <= head.status;
			if (head.status == ST_OK) begin
				split_near   <= rd_entry.near_b;
				split_far    <= rd_entry.far_b;
				depth_scale  <= rd_entry.scale;
				depth_offset <= rd_entry.offset;
			end else begin
				split_near   <= '0;
				split_far    <= '0;
				depth_scale  <= '0;
				depth_offset <= '0;
			end
		end
	end

endmodule

// File: dv/csd_checker.sv
`timescale 1ns / 1ps
// Checker of the cascade split distance block: follows register writes, predicts each item.
// Compares every result in order. Depends on csd_pkg for status and register codes and constants.
module csd_checker import csd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  sub_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] split_near,
	input  logic [31:0] split_far,
	input  logic [31:0] depth_scale,
	input  logic [31:0] depth_offset,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending,
	output int          checked
);
	typedef struct packed {
		bit [31:0] near_b;
		bit [31:0] far_b;
		bit [31:0] scale;
		bit [31:0] offset;
		bit [1:0]  st;
	} split_t;

	bit [31:0] near_r, far_r;
	bit [16:0] weight_r;
	bit [3:0]  count_r;
	split_t    split_q[$];

	function automatic bit [63:0] isqrt(input bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] log2_q24(input bit [31:0] x);
		int unsigned p;
		bit [63:0] m, frac;
		p = 31;
		frac = 0;
		while (p > 0 && x[p] == 1'b0) p--;
		if (p <= 30) m = 64'(x) << (30 - p);
		else m = 64'(x) >> 1;
		for (int j = 0; j < 24; j++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd2 << 30)) begin
				m >>= 1;
				frac |= 1;
			end
		end
		return (64'(p) << 24) | frac;
	endfunction

	function automatic bit [31:0] split_at(input bit [63:0] k, input bit [63:0] cnt,
			input bit [31:0] n, input bit [31:0] f, input bit [63:0] w);
		bit [63:0] uni, lg, ln, lf, diff, e, ef, r, s, prod, ei;
		if (k == 0) return n;
		if (k >= cnt) return f;
		uni = 64'(n) + (64'(f - n) * k) / cnt;
		ln = log2_q24(n);
		lf = log2_q24(f);
		diff = (lf > ln) ? lf - ln : 0;
		e = (diff * k) / cnt;
		ei = e >> 24;
		ef = e & 64'hFF_FFFF;
		r = 64'd1 << 30;
		s = 64'd2 << 30;
		for (int j = 1; j <= 24; j++) begin
			s = isqrt(s << 30);
			if (ef[24-j]) r = (r * s) >> 30;
		end
		prod = 64'(n) * r;
		if (ei > 31) lg = f;
		else if (ei <= 30) lg = prod >> (30 - ei);
		else begin
			lg = prod << 1;
			if (prod[63]) lg = f;
		end
		if (lg > f) lg = f;
		return 32'((lg * w + uni * (64'd65536 - w)) >> 16);
	endfunction

	function automatic bit [31:0] neg_quot(input bit [63:0] num, input bit [63:0] den);
		bit [63:0] q;
		if (den == 0) return SAT_NEG;
		q = num / den;
		if (q >= 64'h8000_0000) return SAT_NEG;
		return 32'd0 - q[31:0];
	endfunction

	function automatic split_t predict_split(input bit [2:0] idx);
		split_t    res;
		bit [63:0] cnt, w, d;
		cnt = (count_r == 0) ? 1 : (count_r > 8) ? 8 : count_r;
		w = (weight_r > WEIGHT_ONE) ? 65536 : weight_r;
		res = '0;
		if (idx >= cnt) res.st = ST_RANGE;
		else if (near_r == 0 || far_r <= near_r) res.st = ST_PLANES;
		else begin
			res.st = ST_OK;
			res.near_b = split_at(idx, cnt, near_r, far_r, w);
			res.far_b = split_at(idx + 1, cnt, near_r, far_r, w);
			d = (res.far_b > res.near_b) ? 64'(res.far_b - res.near_b) : 0;
			res.scale = neg_quot(64'd1 << 33, d);
			res.offset = neg_quot((64'(res.far_b) + res.near_b) << 16, d);
		end
		return res;
	endfunction

	task automatic compare(input string fld, input bit [31:0] exp_v, input bit [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s expected %h actual %h", $realtime, fld, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		split_t e;
		if (!arst_n) begin
			near_r <= 32'd65536;
			far_r <= 32'd6553600;
			weight_r <= 17'd32768;
			count_r <= 4'd4;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_NEAR: near_r <= cfg_data;
				REG_FAR: far_r <= cfg_data;
				REG_WEIGHT: weight_r <= cfg_data[16:0];
				REG_COUNT: count_r <= cfg_data[3:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall) split_q.push_back(predict_split(sub_index));
			if (out_valid && !out_stall) begin
				if (split_q.size() == 0) begin
					$display("%0t unexpected result expected none actual near %h status %0d",
						$realtime, split_near, status);
					errors++;
				end else begin
					e = split_q.pop_front();
					compare("split_near", e.near_b, split_near);
					compare("split_far", e.far_b, split_far);
					compare("depth_scale", e.scale, depth_scale);
					compare("depth_offset", e.offset, depth_offset);
					compare("status", 32'(e.st), 32'(status));
					checked++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		checked = 0;
	end
	assign pending = split_q.size();
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the cascade split distance block: registers, indexes, idling.
// Depends on csd_pkg, the block and csd_checker.
module tb_top import csd_pkg::*;;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] sub_index;
	logic [31:0] split_near, split_far;
	logic signed [31:0] depth_scale, depth_offset;
	logic [1:0] status;
	int errors, pending, checked;
	int tx_pct, rx_pct, idle_cycles, sent;
	bit in_acc, hold_req;

	cascade_split_distances i_dut (.*);
	csd_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		in_acc <= in_valid && !in_stall;
		idle_cycles <= (in_valid && !in_stall || out_valid && !out_stall || cfg_we) ? 0 :
			idle_cycles + 1;
	end

	always @(posedge clk)
		if (idle_cycles > 60000) begin
			$display("CHECK FAILED");
			$finish;
		end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		out_stall = 1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end
			out_stall = ($urandom_range(0, 99) < rx_pct);
		end
	end

	task automatic send(input bit [2:0] idx);
		while ($urandom_range(0, 99) < tx_pct) begin
			in_valid = 0;
			sub_index = 3'($urandom);
			@(negedge clk);
		end
		in_valid = 1;
		sub_index = idx;
		do @(negedge clk); while (!in_acc);
		in_valid = 0;
		sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		while (in_stall) @(negedge clk);
	endtask

	task automatic set_all(input bit [31:0] n, input bit [31:0] f, input bit [16:0] w,
			input bit [3:0] c);
		write_reg(REG_NEAR, n);
		write_reg(REG_FAR, f);
		write_reg(REG_WEIGHT, ($urandom & 32'hFFFE_0000) | w);
		write_reg(REG_COUNT, ($urandom & 32'hFFFF_FFF0) | c);
	endtask

	initial begin
		bit [31:0] n, f;
		int nitems;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_NEAR;
		cfg_data = 0;
		in_valid = 0;
		sub_index = 0;
		hold_req = 0;
		sent = 0;
		tx_pct = 22;
		rx_pct = 84;
		repeat (9) @(negedge clk);
		arst_n = 1;
		for (int i = 0; i < 8; i++) send(3'(i));
		set_all(32'd1, 32'hFFFF_FFFF, 17'd0, 4'd8);
		send(0);
		send(7);
		set_all(32'd65536, 32'd6553600, 17'h1FFFF, 4'd15);
		send(7);
		send(3);
		set_all(32'd65536, 32'd655360, WEIGHT_ONE, 4'd0);
		send(0);
		send(1);
		set_all(32'd0, 32'd655360, 17'd100, 4'd2);
		send(0);
		write_reg(REG_NEAR, 32'd655360);
		send(1);
		write_reg(REG_NEAR, 32'hFFFF_FFFF);
		send(0);
		set_all(32'd100, 32'd102, 17'd40000, 4'd8);
		for (int i = 0; i < 4; i++) send(3'(i));
		for (int ph = 0; ph < 15; ph++) begin
			if (ph == 5) begin tx_pct = 84; rx_pct = 22; end
			if (ph == 10) begin tx_pct = 0; rx_pct = 0; end
			case ($urandom_range(0, 3))
			0: begin n = $urandom; f = $urandom; end
			1: begin n = $urandom_range(1, 32'h0010_0000); f = n + $urandom_range(1, 2000); end
			default: begin
				n = $urandom_range(1, 32'h0100_0000);
				f = n + $urandom_range(1, 32'hFE00_0000);
			end
			endcase
			set_all(n, f, 17'($urandom_range(0, 70000)), 4'($urandom_range(0, 15)));
			if (ph == 12) hold_req = 1;
			nitems = 50;
			for (int i = 0; i < nitems; i++) send(3'($urandom));
		end
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("Covered %0d indexes, %0d results checked, over 20 register settings", sent,
			checked);
		$display("with range, plane and empty-interval cases and three idling mixes.");
		if (errors == 0 && pending == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
